FILE: sv/perspective_fov_projection_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the perspective projection core
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_FOV_PROJECTION_CORE_MACROS_SVH
`define PERSPECTIVE_FOV_PROJECTION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PFP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("pfp check failed");
`define PFP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pfp check failed");
`else
`define PFP_ASSERT(lbl, clk, rstn, prop)
`define PFP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: sv/pfp_pkg.sv
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared constants, types and helpers of the perspective projection core.
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  localparam logic [63:0] S5_Q48 = 64'd6724398;
  localparam logic [63:0] S4_Q48 = 64'd774775692;
  localparam logic [63:0] S3_Q48 = 64'd55847095471;
  localparam logic [63:0] S2_Q48 = 64'd2345624149147;
  localparam logic [63:0] S1_Q48 = 64'd46912497056693;
  localparam logic [63:0] C5_Q48 = 64'd73328777;
  localparam logic [63:0] C4_Q48 = 64'd6969459753;
  localparam logic [63:0] C3_Q48 = 64'd390923087410;
  localparam logic [63:0] C2_Q48 = 64'd11728115960661;
  localparam logic [63:0] C1_Q48 = 64'd140737488355328;

  localparam int unsigned DIV_NUM_W = 48;
  localparam int unsigned DIV_DEN_W = 33;
  localparam int unsigned RES_W     = 32;

  localparam logic signed [RES_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [RES_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic full;
    logic empty;
  } pfp_queue_stat_t;

  function automatic logic [63:0] to_q(input logic [63:0] c48, input int f);
    return (c48 + (64'd1 << (47 - f))) >> (48 - f);
  endfunction

  function automatic logic [63:0] pi_q(input int f);
    return (PI_Q60 + (64'd1 << (59 - f))) >> (60 - f);
  endfunction

  function automatic logic [63:0] pi_half_q(input int f);
    return (PI_Q60 + (64'd1 << (60 - f))) >> (61 - f);
  endfunction

  function automatic logic signed [RES_W-1:0] sat32(input logic neg, input logic ovf,
                                                    input logic [RES_W-1:0] m);
    if (neg) begin
      return (ovf || m > 32'h8000_0000) ? SAT_MIN : $signed(32'd0 - m);
    end
    return (ovf || m[RES_W-1]) ? SAT_MAX : $signed(m);
  endfunction

endpackage

FILE: sv/pfp_if.sv
// ----------------------------------------------------------------------------
// pfp_req_if / pfp_rsp_if
// Valid/ready channels for camera requests and matrix entries.
// ----------------------------------------------------------------------------
interface pfp_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] fov_angle;
  logic [15:0] aspect_ratio;
  logic [31:0] near_depth;
  logic [31:0] far_depth;

  modport source (output valid, fov_angle, aspect_ratio, near_depth, far_depth,
                  input ready);
  modport sink (input valid, fov_angle, aspect_ratio, near_depth, far_depth,
                output ready);
endinterface

interface pfp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] width_scale;
  logic signed [31:0] height_scale;
  logic signed [31:0] depth_scale;
  logic signed [31:0] depth_offset;
  logic               degenerate;

  modport source (output valid, width_scale, height_scale, depth_scale, depth_offset,
                  degenerate, input ready);
  modport sink (input valid, width_scale, height_scale, depth_scale, depth_offset,
                degenerate, output ready);
endinterface

FILE: sv/pfp_fifo.sv
// ----------------------------------------------------------------------------
// pfp_fifo
// Small register queue between the front and back sections.
// ----------------------------------------------------------------------------
module pfp_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_valid_i,
  output logic                     push_ready_o,
  input  logic [W-1:0]             push_data_i,
  output logic                     pop_valid_o,
  input  logic                     pop_ready_i,
  output logic [W-1:0]             pop_data_o,
  output pfp_pkg::pfp_queue_stat_t stat_o
);
  import pfp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign stat_o.full  = !push_ready_o;
  assign stat_o.empty = !pop_valid_o;

  always_comb begin
    wr_d  = push ? ((wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop ? ((rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/pfp_front.sv
// ----------------------------------------------------------------------------
// pfp_front
// Accepts requests, forms the half angle and folds it into [0, pi/2].
// ----------------------------------------------------------------------------
module pfp_front #(
  parameter int unsigned POLY_FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [15:0]          fov_angle_i,
  input  logic [15:0]          aspect_ratio_i,
  input  logic [31:0]          near_depth_i,
  input  logic [31:0]          far_depth_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [POLY_FRAC_BITS+83:0] out_data_o
);
  import pfp_pkg::*;

  localparam int unsigned F  = POLY_FRAC_BITS;
  localparam int unsigned PW = F + 3;
  localparam logic [PW-1:0] PI_F  = PW'(pi_q(F));
  localparam logic [PW-1:0] PIH_F = PW'(pi_half_q(F));

  logic          v_q;
  logic [PW-1:0] y_full, y_d, y_q;
  logic          flip_d, flip_q;
  logic [15:0]   aspect_q;
  logic [31:0]   near_q, far_q;

  assign in_ready_o  = !v_q || out_ready_i;
  assign out_valid_o = v_q;
  assign out_data_o  = {y_q, flip_q, aspect_q, near_q, far_q};

  always_comb begin
    y_full = PW'(fov_angle_i) << (F - 15);
    flip_d = y_full > PIH_F;
    y_d    = flip_d ? PI_F - y_full : y_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      y_q      <= y_d;
      flip_q   <= flip_d;
      aspect_q <= aspect_ratio_i;
      near_q   <= near_depth_i;
      far_q    <= far_depth_i;
    end
  end

endmodule

FILE: sv/pfp_div.sv
// ----------------------------------------------------------------------------
// pfp_div
// Pipelined restoring divider, one quotient bit per stage, rounded half away
// from zero and saturated to 32 bits signed.
// ----------------------------------------------------------------------------
module pfp_div #(
  parameter int unsigned SBW = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [pfp_pkg::DIV_NUM_W-1:0]   num_mag_i,
  input  logic                            num_neg_i,
  input  logic [pfp_pkg::DIV_DEN_W-1:0]   den_mag_i,
  input  logic                            den_neg_i,
  input  logic [SBW-1:0]                  sb_i,
  output logic                            valid_o,
  output logic signed [pfp_pkg::RES_W-1:0] quo_o,
  output logic                            deg_o,
  output logic [SBW-1:0]                  sb_o
);
  import pfp_pkg::*;

  localparam int unsigned NW = DIV_NUM_W + 2;
  localparam int unsigned DW = DIV_DEN_W + 1;
  localparam int unsigned QW = RES_W;

  typedef struct packed {
    logic ovf;
    logic neg;
    logic deg;
    logic num_zero;
    logic num_neg;
  } div_flags_t;

  logic [NW-1:0]    n2;
  logic [DW-1:0]    d2;
  div_flags_t       fl_d;

  logic             v_q    [QW+1];
  logic [DW-1:0]    rem_q  [QW+1];
  logic [QW-1:0]    low_q  [QW+1];
  logic [QW-1:0]    quo_q  [QW+1];
  logic [DW-1:0]    den_q  [QW+1];
  div_flags_t       fl_q   [QW+1];
  logic [SBW-1:0]   sb_q   [QW+1];

  logic                     vo_q;
  logic signed [QW-1:0]     res_q;
  logic                     dego_q;
  logic [SBW-1:0]           sbo_q;

  always_comb begin
    n2          = NW'({num_mag_i, 1'b0}) + NW'(den_mag_i);
    d2          = {den_mag_i, 1'b0};
    fl_d.ovf    = DW'(n2[NW-1:QW]) >= d2;
    fl_d.neg    = num_neg_i ^ den_neg_i;
    fl_d.deg    = den_mag_i == '0;
    fl_d.num_zero = num_mag_i == '0;
    fl_d.num_neg  = num_neg_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DW'(n2[NW-1:QW]);
      low_q[0] <= n2[QW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= d2;
      fl_q[0]  <= fl_d;
      sb_q[0]  <= sb_i;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    logic [DW:0] t;
    logic        ge;

    always_comb begin
      t  = {rem_q[i-1], low_q[i-1][QW-1]};
      ge = t >= {1'b0, den_q[i-1]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? DW'(t - {1'b0, den_q[i-1]}) : DW'(t);
        low_q[i] <= {low_q[i-1][QW-2:0], 1'b0};
        quo_q[i] <= {quo_q[i-1][QW-2:0], ge};
        den_q[i] <= den_q[i-1];
        fl_q[i]  <= fl_q[i-1];
        sb_q[i]  <= sb_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (fl_q[QW].deg) begin
        res_q <= fl_q[QW].num_zero ? '0 : (fl_q[QW].num_neg ? SAT_MIN : SAT_MAX);
      end else begin
        res_q <= sat32(fl_q[QW].neg, fl_q[QW].ovf, quo_q[QW]);
      end
      dego_q <= fl_q[QW].deg;
      sbo_q  <= sb_q[QW];
    end
  end

  assign valid_o = vo_q;
  assign quo_o   = res_q;
  assign deg_o   = dego_q;
  assign sb_o    = sbo_q;

endmodule

FILE: sv/pfp_back.sv
// ----------------------------------------------------------------------------
// pfp_back
// Sine/cosine polynomials, the three divisions and the depth offset.
// ----------------------------------------------------------------------------
module pfp_back #(
  parameter int unsigned POLY_FRAC_BITS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [POLY_FRAC_BITS+83:0] in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [31:0]         width_scale_o,
  output logic signed [31:0]         height_scale_o,
  output logic signed [31:0]         depth_scale_o,
  output logic signed [31:0]         depth_offset_o,
  output logic                       degenerate_o
);
  import pfp_pkg::*;

  localparam int unsigned F  = POLY_FRAC_BITS;
  localparam int unsigned PW = F + 3;
  localparam int unsigned NH = 6;

  localparam logic signed [PW-1:0] S_INIT = PW'(64'd0 - to_q(S5_Q48, F));
  localparam logic signed [PW-1:0] C_INIT = PW'(64'd0 - to_q(C5_Q48, F));
  localparam logic signed [PW-1:0] ONE_F  = PW'(64'd1 << F);
  localparam logic signed [PW-1:0] S_ADD [5] = '{
    PW'(to_q(S4_Q48, F)), PW'(64'd0 - to_q(S3_Q48, F)), PW'(to_q(S2_Q48, F)),
    PW'(64'd0 - to_q(S1_Q48, F)), ONE_F};
  localparam logic signed [PW-1:0] C_ADD [5] = '{
    PW'(to_q(C4_Q48, F)), PW'(64'd0 - to_q(C3_Q48, F)), PW'(to_q(C2_Q48, F)),
    PW'(64'd0 - to_q(C1_Q48, F)), ONE_F};

  function automatic logic [PW-1:0] magp(input logic signed [PW-1:0] a);
    return a[PW-1] ? PW'(-a) : PW'(a);
  endfunction

  function automatic logic signed [PW-1:0] mulq(input logic signed [PW-1:0] a,
                                                input logic signed [PW-1:0] b);
    logic [2*PW-1:0] p;
    logic [2*PW-1:0] r;
    p = (2*PW)'(magp(a)) * (2*PW)'(magp(b));
    r = (p + ((2*PW)'(1) << (F - 1))) >> F;
    return (a[PW-1] ^ b[PW-1]) ? PW'(-r) : PW'(r);
  endfunction

  logic               en;
  logic signed [PW-1:0] y_in;
  logic               flip_in;
  logic [15:0]        aspect_in;
  logic [31:0]        near_in, far_in;

  assign {y_in, flip_in, aspect_in, near_in, far_in} = in_data_i;

  logic                 hv_q     [NH];
  logic signed [PW-1:0] y_q      [NH];
  logic signed [PW-1:0] y2_q     [NH];
  logic                 flip_q   [NH];
  logic signed [PW-1:0] ts_q     [NH];
  logic signed [PW-1:0] tc_q     [NH];
  logic [15:0]          aspect_q [NH];
  logic [31:0]          near_q   [NH];
  logic [31:0]          far_q    [NH];

  logic                 out_v_q;
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q[0] <= 1'b0;
    end else if (en) begin
      hv_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y_q[0]      <= y_in;
      y2_q[0]     <= mulq(y_in, y_in);
      flip_q[0]   <= flip_in;
      ts_q[0]     <= S_INIT;
      tc_q[0]     <= C_INIT;
      aspect_q[0] <= aspect_in;
      near_q[0]   <= near_in;
      far_q[0]    <= far_in;
    end
  end

  for (genvar k = 1; k < NH; k++) begin : g_horner
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hv_q[k] <= 1'b0;
      end else if (en) begin
        hv_q[k] <= hv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        y_q[k]      <= y_q[k-1];
        y2_q[k]     <= y2_q[k-1];
        flip_q[k]   <= flip_q[k-1];
        ts_q[k]     <= mulq(ts_q[k-1], y2_q[k-1]) + S_ADD[k-1];
        tc_q[k]     <= mulq(tc_q[k-1], y2_q[k-1]) + C_ADD[k-1];
        aspect_q[k] <= aspect_q[k-1];
        near_q[k]   <= near_q[k-1];
        far_q[k]    <= far_q[k-1];
      end
    end
  end

  logic                 sc_v_q;
  logic signed [PW-1:0] sin_q, cos_q;
  logic [15:0]          sc_aspect_q;
  logic [31:0]          sc_near_q, sc_far_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v_q <= 1'b0;
    end else if (en) begin
      sc_v_q <= hv_q[NH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sin_q       <= mulq(ts_q[NH-1], y_q[NH-1]);
      cos_q       <= flip_q[NH-1] ? -tc_q[NH-1] : tc_q[NH-1];
      sc_aspect_q <= aspect_q[NH-1];
      sc_near_q   <= near_q[NH-1];
      sc_far_q    <= far_q[NH-1];
    end
  end

  // height = cos / sin
  logic               h_v, h_deg;
  logic signed [31:0] h_quo;
  logic [79:0]        h_sb;

  pfp_div #(.SBW(80)) u_div_height (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (sc_v_q),
    .num_mag_i (DIV_NUM_W'(magp(cos_q)) << 16),
    .num_neg_i (cos_q[PW-1]),
    .den_mag_i (DIV_DEN_W'(magp(sin_q))),
    .den_neg_i (sin_q[PW-1]),
    .sb_i      ({sc_aspect_q, sc_near_q, sc_far_q}),
    .valid_o   (h_v),
    .quo_o     (h_quo),
    .deg_o     (h_deg),
    .sb_o      (h_sb)
  );

  logic [15:0] h_aspect;
  logic [31:0] h_near, h_far;
  logic [31:0] h_mag;
  logic [32:0] dz;

  assign {h_aspect, h_near, h_far} = h_sb;
  assign h_mag = h_quo[31] ? 32'd0 - 32'(h_quo) : 32'(h_quo);
  assign dz    = {1'b0, h_far} - {1'b0, h_near};

  // width = height / aspect, depth = far / (far - near), side by side
  logic               w_v, w_deg, w_unused_v;
  logic signed [31:0] w_quo;
  logic [32:0]        w_sb;
  logic               d_deg;
  logic signed [31:0] d_quo;
  logic [31:0]        d_sb;

  pfp_div #(.SBW(33)) u_div_width (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (h_v),
    .num_mag_i (DIV_NUM_W'(h_mag) << 8),
    .num_neg_i (h_quo[31]),
    .den_mag_i (DIV_DEN_W'(h_aspect)),
    .den_neg_i (1'b0),
    .sb_i      ({h_quo, h_deg}),
    .valid_o   (w_v),
    .quo_o     (w_quo),
    .deg_o     (w_deg),
    .sb_o      (w_sb)
  );

  pfp_div #(.SBW(32)) u_div_depth (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (h_v),
    .num_mag_i (DIV_NUM_W'(h_far) << 16),
    .num_neg_i (1'b0),
    .den_mag_i (dz[32] ? 33'd0 - dz : dz),
    .den_neg_i (dz[32]),
    .sb_i      (h_near),
    .valid_o   (w_unused_v),
    .quo_o     (d_quo),
    .deg_o     (d_deg),
    .sb_o      (d_sb)
  );

  // offset = -depth * near
  logic               o_v_q;
  logic [63:0]        pm_q;
  logic signed [31:0] o_depth_q, o_width_q, o_height_q;
  logic               o_deg_q;
  logic [31:0]        d_mag;
  logic [64:0]        pr;

  assign d_mag = d_quo[31] ? 32'd0 - 32'(d_quo) : 32'(d_quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (en) begin
      o_v_q <= w_v && w_unused_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm_q       <= 64'(d_mag) * 64'(d_sb);
      o_depth_q  <= d_quo;
      o_width_q  <= w_quo;
      o_height_q <= $signed(w_sb[32:1]);
      o_deg_q    <= w_sb[0] || w_deg || d_deg;
    end
  end

  assign pr = 65'(pm_q) + 65'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= o_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      width_scale_o  <= o_width_q;
      height_scale_o <= o_height_q;
      depth_scale_o  <= o_depth_q;
      depth_offset_o <= sat32(!o_depth_q[31], |pr[64:48], pr[47:16]);
      degenerate_o   <= o_deg_q;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

FILE: sv/perspective_fov_projection_core.sv
// ----------------------------------------------------------------------------
// perspective_fov_projection_core
// Left-handed perspective matrix entries from field of view, aspect, near, far.
// ----------------------------------------------------------------------------
// channel | dir | fields
// req_i   | in  | fov_angle Q2.14, aspect_ratio Q8.8, near_depth, far_depth Q16.16
// rsp_o   | out | width/height/depth scale, depth_offset Q16.16, degenerate
//
// One transaction per cycle sustained while responses are taken; a request passes the
// front register, the queue, the polynomial stages, the two chained dividers (height,
// then width and depth side by side) and the offset stages on its way to the response.
// rst_ni clears all valid bits and the queue; no clearing pass.
// A stalled response freezes the back pipeline; the 2-entry queue and the
// front register keep taking requests until they fill.
// ----------------------------------------------------------------------------
`include "perspective_fov_projection_core_macros.svh"

module perspective_fov_projection_core #(
  parameter int unsigned POLY_FRAC_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfp_req_if.sink   req_i,
  pfp_rsp_if.source rsp_o
);
  import pfp_pkg::*;

  localparam int unsigned QDW = POLY_FRAC_BITS + 84;

  logic                 f_valid, f_ready;
  logic [QDW-1:0]       f_data;
  logic                 b_valid, b_ready;
  logic [QDW-1:0]       b_data;
  pfp_queue_stat_t      q_stat;

  pfp_front #(.POLY_FRAC_BITS(POLY_FRAC_BITS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_i.valid),
    .in_ready_o     (req_i.ready),
    .fov_angle_i    (req_i.fov_angle),
    .aspect_ratio_i (req_i.aspect_ratio),
    .near_depth_i   (req_i.near_depth),
    .far_depth_i    (req_i.far_depth),
    .out_valid_o    (f_valid),
    .out_ready_i    (f_ready),
    .out_data_o     (f_data)
  );

  pfp_fifo #(.W(QDW), .DEPTH(2)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data),
    .stat_o       (q_stat)
  );

  pfp_back #(.POLY_FRAC_BITS(POLY_FRAC_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (b_valid),
    .in_ready_o     (b_ready),
    .in_data_i      (b_data),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .width_scale_o  (rsp_o.width_scale),
    .height_scale_o (rsp_o.height_scale),
    .depth_scale_o  (rsp_o.depth_scale),
    .depth_offset_o (rsp_o.depth_offset),
    .degenerate_o   (rsp_o.degenerate)
  );

  `PFP_ASSERT_ALWAYS(a_queue_stat, clk_i, !(q_stat.full && q_stat.empty))
  `PFP_ASSERT(a_offset_pos, clk_i, rst_ni, rsp_o.valid && rsp_o.depth_scale > 0 |-> rsp_o.depth_offset <= 0)
  `PFP_ASSERT(a_offset_neg, clk_i, rst_ni, rsp_o.valid && rsp_o.depth_scale < 0 |-> rsp_o.depth_offset >= 0)
  `PFP_ASSERT(a_width_sign, clk_i, rst_ni, rsp_o.valid && rsp_o.height_scale >= 0 |-> rsp_o.width_scale >= 0)

endmodule

FILE: test/tb_perspective_fov_projection_core.sv
// ----------------------------------------------------------------------------
// tb_perspective_fov_projection_core
// Self-checking bench: camera requests go in over a valid/ready channel, a
// scoreboard predicts each set of matrix entries in fixed point and checks the
// responses in order, under several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_perspective_fov_projection_core;

  localparam int          FRAC    = 24;
  localparam int          WD_MAX  = 5000;
  localparam int          TAIL    = 200;
  localparam int          HOLD    = 400;
  localparam int          N_PHASE = 460;
  localparam int unsigned FOV_MAX = 51471;

  typedef struct packed {
    logic [15:0] fov;
    logic [15:0] aspect;
    logic [31:0] near_d;
    logic [31:0] far_d;
  } cam_req_t;

  typedef struct packed {
    logic signed [31:0] width_s;
    logic signed [31:0] height_s;
    logic signed [31:0] depth_s;
    logic signed [31:0] offset;
    logic               degen;
  } mat_entry_t;

  class matrix_scoreboard;
    mat_entry_t expected_q[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    static function longint unsigned magn(longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
    endfunction

    static function longint qmul(longint a, longint b);
      longint unsigned r;
      r = (magn(a) * magn(b) + (64'd1 << (FRAC - 1))) >> FRAC;
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    static function longint coef(logic [63:0] c48);
      return longint'((c48 + (64'd1 << (47 - FRAC))) >> (48 - FRAC));
    endfunction

    static function longint clamp(bit neg, longint unsigned m);
      if (neg) return m > 64'd2147483648 ? -64'sd2147483648 : -longint'(m);
      return m > 64'd2147483647 ? 64'sd2147483647 : longint'(m);
    endfunction

    static function longint div_round(longint num, longint den, inout bit degen);
      longint unsigned n, d;
      n = magn(num);
      d = magn(den);
      if (d == 0) begin
        degen = 1'b1;
        if (num == 0) return 0;
        return num < 0 ? -64'sd2147483648 : 64'sd2147483647;
      end
      return clamp((num < 0) != (den < 0), (2 * n + d) / (2 * d));
    endfunction

    static function mat_entry_t project(cam_req_t r);
      mat_entry_t      e;
      longint          one, pi_f, half_pi_f, y, y2, t, s, c, h, w, dz, nr, fr;
      longint unsigned pm;
      bit              flip, degen;
      one       = 64'sd1 << FRAC;
      pi_f      = longint'((pfp_pkg::PI_Q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
      half_pi_f = longint'((pfp_pkg::PI_Q60 + (64'd1 << (60 - FRAC))) >> (61 - FRAC));
      degen = 1'b0;
      flip  = 1'b0;
      y = longint'({48'd0, r.fov}) << (FRAC - 15);
      if (y > half_pi_f) begin
        y    = pi_f - y;
        flip = 1'b1;
      end
      y2 = qmul(y, y);
      t = -coef(pfp_pkg::S5_Q48);
      t = qmul(t, y2) + coef(pfp_pkg::S4_Q48);
      t = qmul(t, y2) - coef(pfp_pkg::S3_Q48);
      t = qmul(t, y2) + coef(pfp_pkg::S2_Q48);
      t = qmul(t, y2) - coef(pfp_pkg::S1_Q48);
      t = qmul(t, y2) + one;
      s = qmul(t, y);
      t = -coef(pfp_pkg::C5_Q48);
      t = qmul(t, y2) + coef(pfp_pkg::C4_Q48);
      t = qmul(t, y2) - coef(pfp_pkg::C3_Q48);
      t = qmul(t, y2) + coef(pfp_pkg::C2_Q48);
      t = qmul(t, y2) - coef(pfp_pkg::C1_Q48);
      t = qmul(t, y2) + one;
      c = flip ? -t : t;
      nr = longint'({32'd0, r.near_d});
      fr = longint'({32'd0, r.far_d});
      h  = div_round(c * 65536, s, degen);
      w  = div_round(h * 256, longint'({48'd0, r.aspect}), degen);
      dz = div_round(fr * 65536, fr - nr, degen);
      pm = (magn(dz) * longint'(nr) + 64'd32768) >> 16;
      e.width_s  = w[31:0];
      e.height_s = h[31:0];
      e.depth_s  = dz[31:0];
      e.offset   = clamp(!(dz < 0), pm);
      e.degen    = degen;
      return e;
    endfunction

    function void note_request(cam_req_t r);
      expected_q.push_back(project(r));
    endfunction

    function void check_entry(mat_entry_t got);
      mat_entry_t exp_e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response %h", $time, got);
        errors++;
        return;
      end
      exp_e = expected_q.pop_front();
      if (got.width_s !== exp_e.width_s) begin
        $display("%0t: width_scale exp %0d got %0d", $time, exp_e.width_s, got.width_s);
        errors++;
      end
      if (got.height_s !== exp_e.height_s) begin
        $display("%0t: height_scale exp %0d got %0d", $time, exp_e.height_s, got.height_s);
        errors++;
      end
      if (got.depth_s !== exp_e.depth_s) begin
        $display("%0t: depth_scale exp %0d got %0d", $time, exp_e.depth_s, got.depth_s);
        errors++;
      end
      if (got.offset !== exp_e.offset) begin
        $display("%0t: depth_offset exp %0d got %0d", $time, exp_e.offset, got.offset);
        errors++;
      end
      if (got.degen !== exp_e.degen) begin
        $display("%0t: degenerate exp %0b got %0b", $time, exp_e.degen, got.degen);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pfp_req_if req();
  pfp_rsp_if rsp();

  perspective_fov_projection_core #(.POLY_FRAC_BITS(FRAC)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req.sink),
    .rsp_o (rsp.source)
  );

  matrix_scoreboard sb = new();
  int  src_idle_pct;
  int  snk_stall_pct;
  bit  hold_req;
  int  quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WD_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // response side: check, then pick next ready
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp.valid && rsp.ready) begin
        sb.check_entry({rsp.width_scale, rsp.height_scale, rsp.depth_scale,
                        rsp.depth_offset, rsp.degenerate});
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_request(cam_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.fov_angle    <= r.fov;
    req.aspect_ratio <= r.aspect;
    req.near_depth   <= r.near_d;
    req.far_depth    <= r.far_d;
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(r);
  endtask

  task automatic send_directed(logic [15:0] fov, logic [15:0] asp, logic [31:0] nr,
                               logic [31:0] fr);
    cam_req_t r;
    r = '{fov: fov, aspect: asp, near_d: nr, far_d: fr};
    send_request(r);
  endtask

  function automatic logic [31:0] rand_depth();
    return $urandom() >> $urandom_range(31);
  endfunction

  task automatic send_random();
    cam_req_t    r;
    int          mode;
    logic [31:0] a, b;
    r.fov    = 16'($urandom_range(FOV_MAX));
    r.aspect = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(65535, 1));
    mode = $urandom_range(99);
    a = rand_depth();
    b = rand_depth();
    if (mode < 65) begin
      r.near_d = (a < b) ? a : b;
      r.far_d  = (a < b) ? b : a;
    end else if (mode < 85) begin
      r.near_d = $urandom();
      r.far_d  = $urandom();
    end else if (mode < 93) begin
      r.near_d = a;
      r.far_d  = a;
    end else begin
      r.near_d = (mode[0]) ? 32'd0 : a;
      r.far_d  = (mode[0]) ? b : 32'd0;
    end
    send_request(r);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni            = 1'b0;
    req.valid         = 1'b0;
    req.fov_angle     = '0;
    req.aspect_ratio  = '0;
    req.near_depth    = '0;
    req.far_depth     = '0;
    src_idle_pct      = 0;
    snk_stall_pct     = 0;
    hold_req          = 1'b0;
    quiet_cycles      = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed(16'd0, 16'd256, 32'h0001_0000, 32'h0064_0000);
    send_directed(16'(FOV_MAX), 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
    send_directed(16'd25735, 16'd256, 32'h0000_8000, 32'h0010_0000);
    send_directed(16'd25736, 16'd256, 32'h0000_8000, 32'h0010_0000);
    send_directed(16'd25737, 16'd1, 32'h0000_0001, 32'h0000_0002);
    send_directed(16'd17157, 16'd0, 32'h0001_0000, 32'h03E8_0000);
    send_directed(16'd1, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_directed(16'd1, 16'hFFFF, 32'd0, 32'd0);
    send_directed(16'd17157, 16'd455, 32'h0064_0000, 32'h0001_0000);
    send_directed(16'd17157, 16'd455, 32'hFFFF_FFFF, 32'd0);
    send_directed(16'd17157, 16'd455, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_directed(16'hFFFF & 16'(FOV_MAX), 16'h8000, 32'h5555_5555, 32'hAAAA_AAAA);
    send_directed(16'h4000, 16'h00FF, 32'hAAAA_AAAA, 32'h5555_5555);
    send_directed(16'h8001, 16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_directed(16'd10, 16'd256, 32'h0000_0001, 32'h7FFF_FFFF);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 73; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 73; end
        default: begin src_idle_pct = 8; snk_stall_pct = 8; end
      endcase
      if (ph == 0 || ph == 3) hold_req = 1'b1;
      for (int i = 0; i < N_PHASE; i++) send_random();
      wait_drained();
    end

    repeat (TAIL) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: perspective_fov_projection_core.f
+incdir+sv
sv/pfp_pkg.sv
sv/pfp_if.sv
sv/pfp_fifo.sv
sv/pfp_front.sv
sv/pfp_div.sv
sv/pfp_back.sv
sv/perspective_fov_projection_core.sv
test/tb_perspective_fov_projection_core.sv
